@@ src/skit_pkg.sv @@
// Package for the sorted key index table.
// Holds sizing constants, status and operation codes, and the item and entry types.
// No dependencies.
`default_nettype none

package skit_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int KEY_W    = 64;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_FIND = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_KEY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic             operation;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    value_out;
  } out_item_t;

  // One table entry as it sits in memory.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

endpackage

`default_nettype wire

@@ src/sorted_key_index_table.sv @@
// Top level of the sorted key index table: sequencer, entry count and output register.
// Depends on skit_pkg and skit_ram.
`default_nettype none

// The table holds up to CAPACITY key and value pairs in ascending key order in
// one synchronous RAM whose entries carry a 64-bit key and a 32-bit value. One
// item is worked on at a time. Every item starts with a binary search; each
// probe issues a read and then compares against the registered read data. If
// the search ends below the count, the entry at the found position is then
// read and compared. A find or an update then ends. An insert of a new key
// moves every larger entry up by one place, each move being a RAM read
// followed by a RAM write; the RAM has a single read port. A put with a zero
// key returns status 1, a put of a new key into a full table returns status 2,
// a find that misses returns status 3; value_out is zero except for a
// successful find. The result of an item sits in an output register, so a
// result waiting for out_ready_i never blocks the search of the next item
// until that item also needs to deliver. Reset clears the state, the entry
// count and the output valid; the RAM needs no clearing because no entry at or
// above the count is ever read.
module sorted_key_index_table (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire skit_pkg::in_item_t   in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output skit_pkg::out_item_t       out_item_o
);

  import skit_pkg::*;

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] S_IDLE   = 3'd0;
  localparam logic [ST_W-1:0] S_SEARCH = 3'd1;
  localparam logic [ST_W-1:0] S_CMP    = 3'd2;
  localparam logic [ST_W-1:0] S_CHECK  = 3'd3;
  localparam logic [ST_W-1:0] S_DECIDE = 3'd4;
  localparam logic [ST_W-1:0] S_SHIFT  = 3'd5;
  localparam logic [ST_W-1:0] S_MOVE   = 3'd6;
  localparam logic [ST_W-1:0] S_RESP   = 3'd7;

  logic [ST_W-1:0]     state_q, state_d;
  logic                op_q;
  logic [KEY_W-1:0]    key_q;
  logic [VAL_W-1:0]    val_q;
  logic [CNT_W-1:0]    lo_q, lo_d;
  logic [CNT_W-1:0]    hi_q, hi_d;
  logic [IDX_W-1:0]    mid_q, mid_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic                match_q, match_d;
  logic [VAL_W-1:0]    fval_q, fval_d;
  logic [STATUS_W-1:0] st_q, st_d;
  logic [VAL_W-1:0]    res_q, res_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_item_q, out_item_d;

  logic                accept;
  logic [CNT_W:0]      mid_sum;
  logic [CNT_W-1:0]    idx_dec;

  logic                ram_wr_en, ram_rd_en;
  logic [IDX_W-1:0]    ram_wr_addr, ram_rd_addr;
  entry_t              ram_wr_data, ram_rd_data;

  skit_ram #(
    .Width($bits(entry_t)),
    .Depth(CAPACITY)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (ram_wr_en),
    .wr_addr_i(ram_wr_addr),
    .wr_data_i(ram_wr_data),
    .rd_en_i  (ram_rd_en),
    .rd_addr_i(ram_rd_addr),
    .rd_data_o(ram_rd_data)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // The midpoint is always below the count, so it fits an entry index.
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign idx_dec = idx_q - 1'b1;

  always_comb begin
    state_d     = state_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    match_d     = match_q;
    fval_d      = fval_q;
    st_d        = st_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    ram_wr_en   = 1'b0;
    ram_wr_addr = lo_q[IDX_W-1:0];
    ram_wr_data = '{key: key_q, value: val_q};
    ram_rd_en   = 1'b0;
    ram_rd_addr = mid_sum[IDX_W:1];

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          lo_d    = '0;
          hi_d    = cnt_q;
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (lo_q < hi_q) begin
          ram_rd_en = 1'b1;
          mid_d     = mid_sum[IDX_W:1];
          state_d   = S_CMP;
        end else if (lo_q < cnt_q) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = lo_q[IDX_W-1:0];
          state_d     = S_CHECK;
        end else begin
          match_d = 1'b0;
          state_d = S_DECIDE;
        end
      end
      S_CMP: begin
        if (ram_rd_data.key < key_q) begin
          lo_d = CNT_W'(mid_q) + 1'b1;
        end else begin
          hi_d = CNT_W'(mid_q);
        end
        state_d = S_SEARCH;
      end
      S_CHECK: begin
        match_d = (ram_rd_data.key == key_q);
        fval_d  = ram_rd_data.value;
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        res_d   = '0;
        state_d = S_RESP;
        if (op_q == OP_FIND) begin
          if (match_q) begin
            st_d  = ST_OK;
            res_d = fval_q;
          end else begin
            st_d = ST_NOT_FOUND;
          end
        end else if (key_q == '0) begin
          st_d = ST_ZERO_KEY;
        end else if (match_q) begin
          ram_wr_en = 1'b1;
          st_d      = ST_OK;
        end else if (cnt_q == CNT_W'(CAPACITY)) begin
          st_d = ST_FULL;
        end else begin
          idx_d   = cnt_q;
          st_d    = ST_OK;
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        // Move entries up from the top down to the insert position.
        if (idx_q > lo_q) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = idx_dec[IDX_W-1:0];
          state_d     = S_MOVE;
        end else begin
          ram_wr_en = 1'b1;
          cnt_d     = cnt_q + 1'b1;
          state_d   = S_RESP;
        end
      end
      S_MOVE: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = idx_q[IDX_W-1:0];
        ram_wr_data = ram_rd_data;
        idx_d       = idx_dec;
        state_d     = S_SHIFT;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_item_d  = '{status: st_q, value_out: res_q};
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= in_item_i.operation;
      key_q <= in_item_i.key;
      val_q <= in_item_i.value_in;
    end
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    mid_q      <= mid_d;
    idx_q      <= idx_d;
    match_q    <= match_d;
    fval_q     <= fval_d;
    st_q       <= st_d;
    res_q      <= res_d;
    out_item_q <= out_item_d;
  end

endmodule

`default_nettype wire

@@ src/skit_ram.sv @@
// Generic synchronous RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module skit_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [Width-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic      [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

@@ bench/tb_sorted_key_index_table.sv @@
// Self-checking testbench for the sorted key index table.
// Drives put and find items with random idling and compares each result against a
// behavioral copy of the table; depends on skit_pkg and the sorted_key_index_table RTL.
`default_nettype none

module tb_sorted_key_index_table;
  import skit_pkg::*;

  localparam int CLK_PERIOD     = 10;
  // Wait after the last item for any result still on its way; this covers an
  // insert at the front of a nearly full table, the slowest kind of item.
  localparam int DRAIN_CYCLES   = 200;
  // Bounds the slowest legal run: roughly 900 items, each at worst an insert at the
  // front of a nearly full table, plus sender gaps, receiver stalls and the long hold-off.
  localparam int TIMEOUT_CYCLES = 1_000_000;
  // Long enough for the block to finish one item, park its result in the
  // output register, take the next item and then stall its input.
  localparam int HOLD_CYCLES    = 400;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  // Behavioral copy of the table: keys in ascending order, values beside them.
  logic [KEY_W-1:0] key_mem [CAPACITY];
  logic [VAL_W-1:0] val_mem [CAPACITY];
  int               entry_cnt = 0;

  // Results predicted for accepted items, oldest first.
  out_item_t        pending_results [$];
  out_item_t        head_result;
  int               fail_count     = 0;
  int               result_num     = 0;

  // Idling knobs, changed by the test tasks between phases.
  int               send_idle_pct  = 0;
  int               recv_stall_pct = 0;
  // Cycles the receiver still has to hold off; counted down by the receiver.
  int               hold_left      = 0;

  sorted_key_index_table dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  always begin
    clk = 1'b1;
    #(CLK_PERIOD / 2);
    clk = 1'b0;
    #(CLK_PERIOD / 2);
  end

  // Applies one accepted item to the table copy and returns the result the
  // block must produce for it. The search finds the first key not below the
  // item's key, just as a lower-bound binary search would.
  function automatic out_item_t table_apply(input in_item_t it);
    out_item_t res;
    int        pos;
    bit        hit;
    res.status    = ST_OK;
    res.value_out = '0;
    pos = 0;
    while (pos < entry_cnt && key_mem[pos] < it.key) pos++;
    hit = (pos < entry_cnt) && (key_mem[pos] == it.key);
    if (it.operation == OP_FIND) begin
      // A zero key is never stored, so a find of zero falls out as a miss.
      if (hit) begin
        res.value_out = val_mem[pos];
      end else begin
        res.status = ST_NOT_FOUND;
      end
    end else if (it.key == '0) begin
      // The zero key check wins over the capacity check.
      res.status = ST_ZERO_KEY;
    end else if (hit) begin
      // Updates succeed even when the table is full.
      val_mem[pos] = it.value_in;
    end else if (entry_cnt >= CAPACITY) begin
      res.status = ST_FULL;
    end else begin
      for (int i = entry_cnt; i > pos; i--) begin
        key_mem[i] = key_mem[i-1];
        val_mem[i] = val_mem[i-1];
      end
      key_mem[pos] = it.key;
      val_mem[pos] = it.value_in;
      entry_cnt++;
    end
    return res;
  endfunction

  // Chooses a key that mostly hits the table, so that updates and successful
  // finds dominate, with neighbors of stored keys, zero, corner values and
  // fully random keys mixed in. New keys are kept rare enough that the table
  // fills slowly over the random traffic and inserts shift many entries.
  function automatic logic [KEY_W-1:0] pick_key();
    int               roll;
    int               idx;
    logic [KEY_W-1:0] k;
    roll = (entry_cnt == 0) ? $urandom_range(99, 78) : $urandom_range(99);
    idx  = (entry_cnt == 0) ? 0 : $urandom_range(entry_cnt - 1);
    if (roll < 70) begin
      k = key_mem[idx];
    end else if (roll < 78) begin
      k = $urandom_range(1) ? key_mem[idx] + 1 : key_mem[idx] - 1;
    end else if (roll < 83) begin
      k = '0;
    end else if (roll < 87) begin
      case ($urandom_range(4))
        0:       k = 64'd1;
        1:       k = '1;
        2:       k = '1 - 64'd1;
        3:       k = 64'd1 << $urandom_range(KEY_W - 1);
        default: k = ~(64'd1 << $urandom_range(KEY_W - 1));
      endcase
    end else begin
      k = {$urandom, $urandom};
    end
    return k;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 20) return '1;
    return $urandom;
  endfunction

  // Offers one item and returns at the rising edge where it is accepted. The
  // sender may first idle for a few cycles; valid only ever changes at a
  // falling edge, and a valid that stays high is never lowered in between.
  task automatic send_item(input logic op, input logic [KEY_W-1:0] k,
                           input logic [VAL_W-1:0] v);
    in_item_t it;
    it.operation = op;
    it.key       = k;
    it.value_in  = v;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(table_apply(it));
  endtask

  task automatic send_random_item();
    send_item(($urandom_range(99) < 40) ? OP_PUT : OP_FIND, pick_key(), pick_value());
  endtask

  // Withdraws valid and waits until every predicted result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Empty-table misses, zero keys, inserts at the back, front and middle,
  // updates, and value extremes.
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(OP_FIND, 64'd0, 32'd0);
    send_item(OP_FIND, 64'd5, 32'hFFFF_FFFF);
    send_item(OP_PUT,  64'd0, 32'hFFFF_FFFF);
    send_item(OP_PUT,  '1, 32'd0);
    send_item(OP_PUT,  64'h8000_0000_0000_0000, 32'h1234_5678);
    send_item(OP_PUT,  64'd1, 32'hFFFF_FFFF);
    send_item(OP_PUT,  64'h5555_5555_5555_5555, 32'hA5A5_A5A5);
    send_item(OP_PUT,  64'hAAAA_AAAA_AAAA_AAAA, 32'h5A5A_5A5A);
    send_item(OP_FIND, '1, 32'd0);
    send_item(OP_FIND, 64'd1, 32'd0);
    send_item(OP_FIND, 64'h8000_0000_0000_0000, 32'd0);
    send_item(OP_FIND, 64'd2, 32'd0);
    send_item(OP_FIND, '1 - 64'd1, 32'd0);
    send_item(OP_PUT,  64'h8000_0000_0000_0000, 32'd0);
    send_item(OP_FIND, 64'h8000_0000_0000_0000, 32'hFFFF_FFFF);
    send_item(OP_PUT,  '1, 32'hFFFF_FFFF);
    send_item(OP_FIND, '1, 32'd0);
    send_item(OP_FIND, 64'd0, 32'hFFFF_FFFF);
    send_item(OP_PUT,  64'd0, 32'd0);
    send_item(OP_FIND, 64'h5555_5555_5555_5555, 32'hFFFF_FFFF);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int n_items, input int idle_pct,
                                     input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n_items) send_random_item();
    wait_drained();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // items back to back, so the output register fills and the input stalls.
  // Afterwards the sender pauses until everything has drained.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = HOLD_CYCLES;
    repeat (10) send_random_item();
    wait_drained();
  endtask

  // Fills the table to capacity, then checks that new keys are refused, that
  // updates still succeed and that the zero key check comes first.
  task automatic test_full_table();
    logic [KEY_W-1:0] k;
    send_idle_pct  = 10;
    recv_stall_pct = 10;
    while (entry_cnt < CAPACITY) begin
      k = {$urandom, $urandom};
      send_item(OP_PUT, (k == '0) ? 64'd3 : k, pick_value());
    end
    send_item(OP_PUT,  {$urandom, $urandom} | 64'd1, 32'hFFFF_FFFF);
    send_item(OP_PUT,  key_mem[0], 32'hFFFF_FFFF);
    send_item(OP_PUT,  key_mem[CAPACITY-1], 32'd0);
    send_item(OP_PUT,  64'd0, 32'h0BAD_0BAD);
    send_item(OP_FIND, key_mem[0], 32'd0);
    send_item(OP_FIND, key_mem[CAPACITY-1], 32'd0);
    repeat (40) send_random_item();
    wait_drained();
  endtask

  // Receiver: ready changes only at falling edges. A pending hold-off is
  // counted down here and overrides the random stalls while it lasts.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Every result taken by the receiver is matched against the oldest
  // prediction; a result with nothing outstanding is a failure of its own.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result %0d arrived with no item outstanding: status %0d value_out %0h",
               result_num, out_item.status, out_item.value_out);
        fail_count++;
      end else begin
        head_result = pending_results.pop_front();
        if (out_item.status !== head_result.status) begin
          $error("result %0d status mismatch: expected %0d, actual %0d",
                 result_num, head_result.status, out_item.status);
          fail_count++;
        end
        if (out_item.value_out !== head_result.value_out) begin
          $error("result %0d value_out mismatch: expected %0h, actual %0h",
                 result_num, head_result.value_out, out_item.value_out);
          fail_count++;
        end
      end
      result_num++;
    end
  end

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    // Random phases: no idling, an idle sender, a stalling receiver, then both.
    test_random_traffic(180, 0, 0);
    test_random_traffic(180, 70, 0);
    test_random_traffic(180, 0, 70);
    test_random_traffic(180, 10, 10);
    test_backpressure();
    test_full_table();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("sorted_key_index_table verification clean");
    end else begin
      $display("sorted_key_index_table verification failed");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("sorted_key_index_table verification failed");
    $finish;
  end

endmodule

`default_nettype wire
